// ===== hdl/active_note_table_defines.svh =====
// Assertion macros for the active note table.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef ACTIVE_NOTE_TABLE_DEFINES_SVH
`define ACTIVE_NOTE_TABLE_DEFINES_SVH

// Check that holds in the same cycle as its trigger.
`define ANT_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that holds in the cycle after its trigger.
`define ANT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ant_pkg.sv =====
// Shared types, field widths and request codes of the active note table.
// No dependencies; imported by the controller, output stage and top level.
package ant_pkg;

    localparam int IN_DATA_W      = 24;
    localparam int OUT_DATA_W     = 16;
    localparam int REQ_W          = 3;
    localparam int OWNER_FIELD_W  = 8;
    localparam int STREAM_FIELD_W = 4;
    localparam int CHAN_W         = 4;
    localparam int NOTE_W         = 7;

    localparam logic [REQ_W-1:0] REQ_ACTIVATE   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DEACTIVATE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_OWNS       = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REL_OWNER  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REL_STREAM = 3'd4;
    localparam logic [REQ_W-1:0] REQ_REL_ALL    = 3'd5;

    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic [OWNER_FIELD_W-1:0]  owner_id;
        logic [STREAM_FIELD_W-1:0] stream_id;
        logic [CHAN_W-1:0]         midi_channel;
        logic [NOTE_W-1:0]         note_number;
    } ant_req_t;

    typedef struct packed {
        logic              ok;
        logic              send_event;
        logic              released_valid;
        logic [CHAN_W-1:0] released_channel;
        logic [NOTE_W-1:0] released_note;
        logic              last;
    } ant_res_t;

    function automatic ant_res_t mk_res(input logic ok, input logic send,
                                        input logic rv, input logic [CHAN_W-1:0] ch,
                                        input logic [NOTE_W-1:0] nt, input logic last);
        ant_res_t r;
        r.ok               = ok;
        r.send_event       = send;
        r.released_valid   = rv;
        r.released_channel = ch;
        r.released_note    = nt;
        r.last             = last;
        return r;
    endfunction

endpackage

// ===== hdl/ant_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the slot entries of the active note table.
module ant_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         aclk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ant_ctrl.sv =====
// Request sequencer of the active note table: slot RAM, valid bits and scans.
// Depends on ant_pkg, ant_ram and active_note_table_defines.svh.
`include "active_note_table_defines.svh"

module ant_ctrl
    import ant_pkg::*;
#(
    parameter int SLOTS       = 16,
    parameter int OWNER_BITS  = 8,
    parameter int STREAM_BITS = 4
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  ant_req_t req,
    input  logic     out_rdy,
    output logic     push,
    output ant_res_t res
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int OWN_W  = (OWNER_BITS < OWNER_FIELD_W) ? OWNER_BITS : OWNER_FIELD_W;
    localparam int STR_W  = (STREAM_BITS < STREAM_FIELD_W) ? STREAM_BITS : STREAM_FIELD_W;
    localparam int ENT_W  = OWN_W + STR_W + CHAN_W + NOTE_W;
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOTS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_FINISH = 3'd2;
    localparam logic [2:0] ST_CAND   = 3'd3;
    localparam logic [2:0] ST_CLATCH = 3'd4;
    localparam logic [2:0] ST_INNER  = 3'd5;
    localparam logic [2:0] ST_DECIDE = 3'd6;
    localparam logic [2:0] ST_RESP   = 3'd7;

    // control state
    logic [2:0]        state_reg, state_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pipe_vld_reg, pipe_vld_next;
    logic              found_reg, found_next;
    logic              free_found_reg, free_found_next;
    logic [1:0]        pitch_cnt_reg, pitch_cnt_next;
    logic              pend_reg, pend_next;
    logic              conflict_reg, conflict_next;
    logic [CNT_W-1:0]  cand_reg, cand_next;
    logic [SLOTS-1:0]  freed_reg, freed_next;

    // payload
    logic [SLOT_W-1:0] pipe_idx_reg, pipe_idx_next;
    logic [SLOT_W-1:0] match_idx_reg, match_idx_next;
    logic [SLOT_W-1:0] free_idx_reg, free_idx_next;
    logic [REQ_W-1:0]  typ_reg, typ_next;
    logic [OWN_W-1:0]  own_reg, own_next;
    logic [STR_W-1:0]  str_reg, str_next;
    logic [CHAN_W-1:0] ch_reg, ch_next;
    logic [NOTE_W-1:0] nt_reg, nt_next;
    logic [CHAN_W-1:0] cand_ch_reg, cand_ch_next;
    logic [NOTE_W-1:0] cand_nt_reg, cand_nt_next;
    logic [CHAN_W-1:0] pend_ch_reg, pend_ch_next;
    logic [NOTE_W-1:0] pend_nt_reg, pend_nt_next;
    ant_res_t          res_reg, res_next;

    // RAM side
    logic              ram_we;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic [ENT_W-1:0]  rd_data;
    logic [OWN_W-1:0]  e_own;
    logic [STR_W-1:0]  e_str;
    logic [CHAN_W-1:0] e_ch;
    logic [NOTE_W-1:0] e_nt;

    logic              is_rel;
    logic              scanning;
    logic              scan_done;
    logic              pv;
    logic              exact_eq;
    logic              pitch_eq;
    logic              cand_eq;
    logic              rel_hit;
    logic              freed_before;
    logic [SLOT_W-1:0] cand_idx;

    ant_ram #(
        .WIDTH(ENT_W),
        .DEPTH(SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (free_idx_reg),
        .wdata ({nt_reg, ch_reg, str_reg, own_reg}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign e_own = rd_data[OWN_W-1:0];
    assign e_str = rd_data[OWN_W +: STR_W];
    assign e_ch  = rd_data[OWN_W + STR_W +: CHAN_W];
    assign e_nt  = rd_data[OWN_W + STR_W + CHAN_W +: NOTE_W];

    assign is_rel    = (typ_reg == REQ_REL_OWNER) || (typ_reg == REQ_REL_STREAM) ||
                       (typ_reg == REQ_REL_ALL);
    assign scanning  = (state_reg == ST_SCAN) || (state_reg == ST_INNER);
    assign scan_done = (cnt_reg == CNT_END) && !pipe_vld_reg;
    assign cand_idx  = cand_reg[SLOT_W-1:0];

    // Reads come from the scan counter, or from the candidate pointer while probing.
    always_comb begin
        rd_addr = cnt_reg[SLOT_W-1:0];
        rd_en   = scanning && (cnt_reg != CNT_END);
        if (state_reg == ST_CAND) begin
            rd_addr = cand_idx;
            rd_en   = (cand_reg != CNT_END) && freed_reg[cand_idx];
        end
    end

    // Compare the entry coming out of the RAM; unwritten entries stay gated by pv.
    assign pv           = valid_reg[pipe_idx_reg];
    assign pitch_eq     = pv && (e_ch == ch_reg) && (e_nt == nt_reg);
    assign exact_eq     = pitch_eq && (e_own == own_reg) && (e_str == str_reg);
    assign rel_hit      = pv && ((typ_reg == REQ_REL_ALL) ||
                                 ((typ_reg == REQ_REL_OWNER) && (e_own == own_reg)) ||
                                 ((typ_reg == REQ_REL_STREAM) && (e_str == str_reg)));
    assign freed_before = freed_reg[pipe_idx_reg] && (CNT_W'(pipe_idx_reg) < cand_reg);
    assign cand_eq      = (pv || freed_before) && (e_ch == cand_ch_reg) &&
                          (e_nt == cand_nt_reg);

    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        pipe_vld_next   = 1'b0;
        pipe_idx_next   = pipe_idx_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        pitch_cnt_next  = pitch_cnt_reg;
        pend_next       = pend_reg;
        conflict_next   = conflict_reg;
        cand_next       = cand_reg;
        freed_next      = freed_reg;
        match_idx_next  = match_idx_reg;
        free_idx_next   = free_idx_reg;
        typ_next        = typ_reg;
        own_next        = own_reg;
        str_next        = str_reg;
        ch_next         = ch_reg;
        nt_next         = nt_reg;
        cand_ch_next    = cand_ch_reg;
        cand_nt_next    = cand_nt_reg;
        pend_ch_next    = pend_ch_reg;
        pend_nt_next    = pend_nt_reg;
        res_next        = res_reg;
        ram_we          = 1'b0;
        push            = 1'b0;
        in_ready        = (state_reg == ST_IDLE);

        // shared streaming scan: one read issued per cycle, compared in the following cycle
        if (scanning) begin
            pipe_vld_next = (cnt_reg != CNT_END);
            pipe_idx_next = cnt_reg[SLOT_W-1:0];
            if (cnt_reg != CNT_END) begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    typ_next        = req.req_type;
                    own_next        = req.owner_id[OWN_W-1:0];
                    str_next        = req.stream_id[STR_W-1:0];
                    ch_next         = req.midi_channel;
                    nt_next         = req.note_number;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    pitch_cnt_next  = 2'd0;
                    pend_next       = 1'b0;
                    freed_next      = '0;
                    cnt_next        = '0;
                    if (req.req_type <= REQ_REL_ALL) begin
                        state_next = ST_SCAN;
                    end else begin
                        res_next   = mk_res(1'b0, 1'b0, 1'b0, '0, '0, 1'b1);
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SCAN: begin
                if (pipe_vld_reg) begin
                    if (is_rel) begin
                        if (rel_hit) begin
                            valid_next[pipe_idx_reg] = 1'b0;
                            freed_next[pipe_idx_reg] = 1'b1;
                        end
                    end else begin
                        if (exact_eq && !found_reg) begin
                            found_next     = 1'b1;
                            match_idx_next = pipe_idx_reg;
                        end
                        if (pitch_eq && (pitch_cnt_reg != 2'd2)) begin
                            pitch_cnt_next = pitch_cnt_reg + 2'd1;
                        end
                        if (!pv && !free_found_reg) begin
                            free_found_next = 1'b1;
                            free_idx_next   = pipe_idx_reg;
                        end
                    end
                end
                if (scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                res_next   = mk_res(1'b0, 1'b0, 1'b0, '0, '0, 1'b1);
                state_next = ST_RESP;
                case (typ_reg)
                    REQ_ACTIVATE: begin
                        if (found_reg) begin
                            res_next.ok = 1'b1;
                        end else if (free_found_reg) begin
                            ram_we                   = 1'b1;
                            valid_next[free_idx_reg] = 1'b1;
                            res_next.ok              = 1'b1;
                            res_next.send_event      = (pitch_cnt_reg == 2'd0);
                        end
                    end
                    REQ_DEACTIVATE: begin
                        if (found_reg) begin
                            valid_next[match_idx_reg] = 1'b0;
                            res_next.ok               = 1'b1;
                            res_next.send_event       = (pitch_cnt_reg == 2'd1);
                        end
                    end
                    REQ_OWNS: begin
                        res_next.ok = found_reg;
                    end
                    default: begin
                        cand_next  = '0;
                        state_next = ST_CAND;
                    end
                endcase
            end
            ST_CAND: begin
                if (cand_reg == CNT_END) begin
                    if (pend_reg) begin
                        res_next  = mk_res(1'b1, 1'b1, 1'b1, pend_ch_reg, pend_nt_reg, 1'b1);
                        pend_next = 1'b0;
                    end else begin
                        res_next  = mk_res(|freed_reg, 1'b0, 1'b0, '0, '0, 1'b1);
                    end
                    state_next = ST_RESP;
                end else if (freed_reg[cand_idx]) begin
                    state_next = ST_CLATCH;
                end else begin
                    cand_next = cand_reg + CNT_W'(1);
                end
            end
            ST_CLATCH: begin
                cand_ch_next  = e_ch;
                cand_nt_next  = e_nt;
                conflict_next = 1'b0;
                cnt_next      = '0;
                state_next    = ST_INNER;
            end
            ST_INNER: begin
                if (pipe_vld_reg && cand_eq) begin
                    conflict_next = 1'b1;
                end
                if (scan_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cand_next  = cand_reg + CNT_W'(1);
                state_next = ST_CAND;
                if (!conflict_reg) begin
                    // hold the new pitch until the next one shows whether it is last
                    pend_next    = 1'b1;
                    pend_ch_next = cand_ch_reg;
                    pend_nt_next = cand_nt_reg;
                    if (pend_reg) begin
                        res_next   = mk_res(1'b1, 1'b1, 1'b1, pend_ch_reg, pend_nt_reg, 1'b0);
                        state_next = ST_RESP;
                    end
                end
            end
            ST_RESP: begin
                if (out_rdy) begin
                    push       = 1'b1;
                    state_next = res_reg.last ? ST_IDLE : ST_CAND;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            cnt_reg        <= '0;
            pipe_vld_reg   <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            pitch_cnt_reg  <= 2'd0;
            pend_reg       <= 1'b0;
            conflict_reg   <= 1'b0;
            cand_reg       <= '0;
            freed_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            cnt_reg        <= cnt_next;
            pipe_vld_reg   <= pipe_vld_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            pitch_cnt_reg  <= pitch_cnt_next;
            pend_reg       <= pend_next;
            conflict_reg   <= conflict_next;
            cand_reg       <= cand_next;
            freed_reg      <= freed_next;
        end
    end

    always_ff @(posedge aclk) begin
        pipe_idx_reg  <= pipe_idx_next;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        typ_reg       <= typ_next;
        own_reg       <= own_next;
        str_reg       <= str_next;
        ch_reg        <= ch_next;
        nt_reg        <= nt_next;
        cand_ch_reg   <= cand_ch_next;
        cand_nt_reg   <= cand_nt_next;
        pend_ch_reg   <= pend_ch_next;
        pend_nt_reg   <= pend_nt_next;
        res_reg       <= res_next;
    end

    assign res = res_reg;

    `ANT_ASSERT_SAME(a_push_room, aclk, aresetn, push, out_rdy, "push into a full output register")
    `ANT_ASSERT_NEXT(a_last_idle, aclk, aresetn, push && res.last, state_reg == ST_IDLE, "no return to idle after last result")
    `ANT_ASSERT_NEXT(a_last_flush, aclk, aresetn, push && res.last, !pend_reg, "pitch left pending after last result")
    `ANT_ASSERT_SAME(a_freed_clear, aclk, aresetn, (state_reg != ST_IDLE) && is_rel, (valid_reg & freed_reg) == '0, "freed slot still marked valid")
    `ANT_ASSERT_SAME(a_fill_free, aclk, aresetn, ram_we, !valid_reg[free_idx_reg], "activate overwrites a valid slot")

endmodule

// ===== hdl/ant_out.sv =====
// Output register of the active note table: holds one result for the stream master.
// Depends on ant_pkg.
module ant_out
    import ant_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  ant_res_t              res,
    output logic                  out_rdy,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    logic     vld_reg, vld_next;
    ant_res_t res_reg;

    assign out_rdy  = !vld_reg || m_tready;
    assign vld_next = push ? 1'b1 : (m_tready ? 1'b0 : vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {(OUT_DATA_W - 2 - CHAN_W - NOTE_W)'(0), res_reg.released_note,
                       res_reg.released_channel, res_reg.send_event, res_reg.ok};
    assign m_tuser  = res_reg.released_valid;
    assign m_tlast  = res_reg.last;

endmodule

// ===== hdl/active_note_table.sv =====
// Activate, deactivate and owns scan every slot through the RAM, then register one result.
// Release: a scan clears matching slots, a probe walks the slots, and each freed slot gets
// a full rescan to check its pitch before its result is sent; the single RAM read port
// serializes these steps. Throughput: one request at a time; the next is taken once the
// last result is registered.
// Reset: synchronous, active low; clears all valid marks, slot RAM contents are not cleared.
module active_note_table
    import ant_pkg::*;
#(
    parameter int SLOTS       = 16,
    parameter int OWNER_BITS  = 8,
    parameter int STREAM_BITS = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // owner_id[7:0], stream_id[11:8],
                                             // midi_channel[15:12], note_number[22:16]
    input  logic [REQ_W-1:0]      s_tuser,   // req_type[2:0]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // ok[0], send_event[1],
                                             // released_channel[5:2], released_note[12:6]
    output logic                  m_tuser,   // released_valid[0]
    output logic                  m_tlast    // last result of this request
);

    ant_req_t req;
    ant_res_t res;
    logic     push;
    logic     out_rdy;

    // Unpack the request transaction into its fields.
    assign req.req_type     = s_tuser;
    assign req.owner_id     = s_tdata[OWNER_FIELD_W-1:0];
    assign req.stream_id    = s_tdata[OWNER_FIELD_W +: STREAM_FIELD_W];
    assign req.midi_channel = s_tdata[OWNER_FIELD_W + STREAM_FIELD_W +: CHAN_W];
    assign req.note_number  = s_tdata[OWNER_FIELD_W + STREAM_FIELD_W + CHAN_W +: NOTE_W];

    // Sequencer: walks the slot RAM, updates valid marks, builds each result.
    ant_ctrl #(
        .SLOTS       (SLOTS),
        .OWNER_BITS  (OWNER_BITS),
        .STREAM_BITS (STREAM_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .req      (req),
        .out_rdy  (out_rdy),
        .push     (push),
        .res      (res)
    );

    // Output register: hold a result until the downstream takes the transaction.
    ant_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .res      (res),
        .out_rdy  (out_rdy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for active_note_table: streams note requests and checks every result.
// Depends on ant_pkg and the active_note_table RTL; holds its own model of the slot table.
module tb_top;
    import ant_pkg::*;

    localparam int SLOTS_N = 16;
    localparam int TAIL_CYCLES = 400;   // idle margin after the last drain, meant to cover the worst release walk
    localparam int RANDOM_PER_PHASE = 20;

    // Spare request codes: the block answers them with ok clear and changes nothing
    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [REQ_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // Requests waiting to be offered, and the request now on the bus
    ant_req_t request_q[$];
    ant_req_t on_bus;
    ant_req_t next_req;
    // Results the table owes us, oldest first
    ant_res_t owed_results[$];
    // Recent activates, reused to build deactivates and owns queries that may hit
    ant_req_t played_notes[$];

    // Model of the slot table
    logic                      slot_on   [SLOTS_N] = '{default: 1'b0};
    logic [OWNER_FIELD_W-1:0]  slot_own  [SLOTS_N];
    logic [STREAM_FIELD_W-1:0] slot_strm [SLOTS_N];
    logic [CHAN_W-1:0]         slot_ch   [SLOTS_N];
    logic [NOTE_W-1:0]         slot_nt   [SLOTS_N];

    int send_gap_pct;
    int recv_stall_pct;
    int errors = 0;
    int issued = 0;

    active_note_table #(
        .SLOTS      (SLOTS_N),
        .OWNER_BITS (8),
        .STREAM_BITS(4)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #1 aclk = ~aclk;

    function automatic bit pitch_sounding(logic [CHAN_W-1:0] ch, logic [NOTE_W-1:0] nt);
        foreach (slot_on[i])
            if (slot_on[i] && slot_ch[i] == ch && slot_nt[i] == nt) return 1'b1;
        return 1'b0;
    endfunction

    function automatic int find_voice(ant_req_t rq);
        foreach (slot_on[i])
            if (slot_on[i] && slot_own[i] == rq.owner_id && slot_strm[i] == rq.stream_id &&
                slot_ch[i] == rq.midi_channel && slot_nt[i] == rq.note_number)
                return i;
        return -1;
    endfunction

    // Update the table model with one accepted request and queue what it owes
    function automatic void apply_to_table(ant_req_t rq);
        ant_res_t         r;
        int               hit;
        logic             freed [SLOTS_N];
        logic             any_freed;
        logic             dup;
        logic [CHAN_W-1:0] off_ch[$];
        logic [NOTE_W-1:0] off_nt[$];
        r = '0;
        r.last = 1'b1;
        case (rq.req_type)
            REQ_ACTIVATE: begin
                if (find_voice(rq) >= 0) begin
                    r.ok = 1'b1;
                end else begin
                    hit = -1;
                    foreach (slot_on[i])
                        if (!slot_on[i] && hit < 0) hit = i;
                    if (hit >= 0) begin
                        r.ok = 1'b1;
                        r.send_event = !pitch_sounding(rq.midi_channel, rq.note_number);
                        slot_on[hit]   = 1'b1;
                        slot_own[hit]  = rq.owner_id;
                        slot_strm[hit] = rq.stream_id;
                        slot_ch[hit]   = rq.midi_channel;
                        slot_nt[hit]   = rq.note_number;
                    end
                end
                owed_results.insert(owed_results.size(), r);
            end
            REQ_DEACTIVATE: begin
                hit = find_voice(rq);
                if (hit >= 0) begin
                    slot_on[hit] = 1'b0;
                    r.ok = 1'b1;
                    r.send_event = !pitch_sounding(rq.midi_channel, rq.note_number);
                end
                owed_results.insert(owed_results.size(), r);
            end
            REQ_OWNS: begin
                r.ok = (find_voice(rq) >= 0);
                owed_results.insert(owed_results.size(), r);
            end
            REQ_REL_OWNER, REQ_REL_STREAM, REQ_REL_ALL: begin
                // Clear every matching slot first, then walk them in slot order
                any_freed = 1'b0;
                foreach (slot_on[i]) begin
                    freed[i] = slot_on[i] && (rq.req_type == REQ_REL_ALL ||
                        (rq.req_type == REQ_REL_OWNER && slot_own[i] == rq.owner_id) ||
                        (rq.req_type == REQ_REL_STREAM && slot_strm[i] == rq.stream_id));
                    if (freed[i]) begin
                        slot_on[i] = 1'b0;
                        any_freed = 1'b1;
                    end
                end
                foreach (slot_on[i]) begin
                    if (freed[i] && !pitch_sounding(slot_ch[i], slot_nt[i])) begin
                        dup = 1'b0;
                        foreach (off_ch[j])
                            if (off_ch[j] == slot_ch[i] && off_nt[j] == slot_nt[i]) dup = 1'b1;
                        if (!dup) begin
                            off_ch.insert(off_ch.size(), slot_ch[i]);
                            off_nt.insert(off_nt.size(), slot_nt[i]);
                        end
                    end
                end
                if (off_ch.size() == 0) begin
                    r.ok = any_freed;
                    owed_results.insert(owed_results.size(), r);
                end else begin
                    foreach (off_ch[j]) begin
                        r.ok               = 1'b1;
                        r.send_event       = 1'b1;
                        r.released_valid   = 1'b1;
                        r.released_channel = off_ch[j];
                        r.released_note    = off_nt[j];
                        r.last             = (j == off_ch.size() - 1);
                        owed_results.insert(owed_results.size(), r);
                    end
                end
            end
            default: begin
                owed_results.insert(owed_results.size(), r);
            end
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Driver: advance to the next request when the current transaction completes
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) apply_to_table(on_bus);
            if (!s_tvalid || s_tready) begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    next_req = request_q.pop_front();
                    on_bus   <= next_req;
                    s_tdata  <= {1'b0, next_req.note_number, next_req.midi_channel,
                                 next_req.stream_id, next_req.owner_id};
                    s_tuser  <= next_req.req_type;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction against the oldest owed result
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result, tdata %h tuser %b tlast %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    ant_res_t want;
                    want = owed_results.pop_front();
                    check_field("ok", int'(want.ok), int'(m_tdata[0]));
                    check_field("send_event", int'(want.send_event), int'(m_tdata[1]));
                    check_field("released_valid", int'(want.released_valid), int'(m_tuser));
                    check_field("released_channel", int'(want.released_channel),
                                int'(m_tdata[5:2]));
                    check_field("released_note", int'(want.released_note),
                                int'(m_tdata[12:6]));
                    check_field("last", int'(want.last), int'(m_tlast));
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic add_req(logic [REQ_W-1:0] kind, logic [7:0] ow, logic [3:0] st,
                           logic [3:0] ch, logic [6:0] nt);
        ant_req_t rq;
        rq.req_type     = kind;
        rq.owner_id     = ow;
        rq.stream_id    = st;
        rq.midi_channel = ch;
        rq.note_number  = nt;
        request_q.insert(request_q.size(), rq);
        if (kind <= REQ_REL_ALL) issued++;
        if (kind == REQ_ACTIVATE) begin
            played_notes.insert(played_notes.size(), rq);
            if (played_notes.size() > 32) void'(played_notes.pop_front());
        end
    endtask

    // Mostly a narrow pitch range so chords share pitches; sometimes anything
    function automatic logic [3:0] pick_channel();
        return 4'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 15));
    endfunction

    function automatic logic [6:0] pick_note();
        return 7'(($urandom_range(0, 3) != 0) ? 60 + $urandom_range(0, 7)
                                              : $urandom_range(0, 127));
    endfunction

    function automatic logic [7:0] pick_owner();
        logic [7:0] pool [4] = '{8'h00, 8'h5A, 8'hA5, 8'hFF};
        return ($urandom_range(0, 1) != 0) ? pool[$urandom_range(0, 3)]
                                           : 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [3:0] pick_stream();
        return 4'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 15));
    endfunction

    // Empty the table, overfill it with scattered pitches, then free everything
    task automatic fill_table();
        add_req(REQ_REL_ALL, 8'($urandom), 4'($urandom), 4'($urandom), 7'($urandom));
        repeat (SLOTS_N + 1)
            add_req(REQ_ACTIVATE, 8'($urandom), 4'($urandom), 4'($urandom), 7'($urandom));
        add_req(REQ_REL_ALL, 8'($urandom), 4'($urandom), 4'($urandom), 7'($urandom));
    endtask

    task automatic add_random(int count);
        int         stop;
        int         roll;
        int         k;
        ant_req_t   h;
        logic [7:0] ow;
        logic [3:0] st;
        stop = issued + count;
        while (issued < stop) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                fill_table();
            end else if (roll < 55) begin
                // Chord from one voice, optional note-off, then usually a release
                ow = pick_owner();
                st = pick_stream();
                k = $urandom_range(1, 5);
                repeat (k) add_req(REQ_ACTIVATE, ow, st, pick_channel(), pick_note());
                if ($urandom_range(0, 1) != 0) begin
                    h = played_notes[$urandom_range(0, played_notes.size() - 1)];
                    add_req(REQ_DEACTIVATE, h.owner_id, h.stream_id, h.midi_channel,
                            h.note_number);
                end
                case ($urandom_range(0, 2))
                    0: add_req(REQ_REL_OWNER, ow, 4'($urandom), 4'($urandom), 7'($urandom));
                    1: add_req(REQ_REL_STREAM, 8'($urandom), st, 4'($urandom), 7'($urandom));
                    default: ;
                endcase
            end else if (roll < 80) begin
                if (played_notes.size() != 0 && $urandom_range(0, 9) < 6) begin
                    h = played_notes[$urandom_range(0, played_notes.size() - 1)];
                    add_req(($urandom_range(0, 1) != 0) ? REQ_DEACTIVATE : REQ_OWNS,
                            h.owner_id, h.stream_id, h.midi_channel, h.note_number);
                end else begin
                    // Noise: any code, any field value
                    add_req(REQ_W'($urandom_range(0, 7)), 8'($urandom), 4'($urandom),
                            4'($urandom), 7'($urandom));
                end
            end else begin
                case ($urandom_range(0, 2))
                    0: add_req(REQ_REL_OWNER, pick_owner(), 4'($urandom), 4'($urandom),
                               7'($urandom));
                    1: add_req(REQ_REL_STREAM, 8'($urandom), pick_stream(), 4'($urandom),
                               7'($urandom));
                    default: add_req(REQ_REL_ALL, 8'($urandom), 4'($urandom), 4'($urandom),
                                     7'($urandom));
                endcase
            end
        end
    endtask

    // Hold until every request went out and every owed result came back
    task automatic drain();
        while (request_q.size() != 0 || s_tvalid || owed_results.size() != 0)
            @(negedge aclk);
    endtask

    initial begin
        send_gap_pct   = 34;
        recv_stall_pct = 60;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty table, spare codes, duplicates, shared pitches, releases
        add_req(REQ_REL_ALL, 8'h00, 4'h0, 4'h0, 7'h00);
        add_req(REQ_OWNS, 8'hFF, 4'hF, 4'hF, 7'h7F);
        add_req(REQ_SPARE_6, 8'hFF, 4'hF, 4'hF, 7'h7F);
        add_req(REQ_SPARE_7, 8'h00, 4'h0, 4'h0, 7'h00);
        add_req(REQ_ACTIVATE, 8'h00, 4'h0, 4'h0, 7'h00);
        add_req(REQ_ACTIVATE, 8'h00, 4'h0, 4'h0, 7'h00);   // exact duplicate
        add_req(REQ_ACTIVATE, 8'h01, 4'h0, 4'h0, 7'h00);   // pitch already sounding
        add_req(REQ_OWNS, 8'h00, 4'h0, 4'h0, 7'h00);
        add_req(REQ_DEACTIVATE, 8'h00, 4'h0, 4'h0, 7'h00); // pitch still held
        add_req(REQ_DEACTIVATE, 8'h00, 4'h0, 4'h0, 7'h00); // no match left
        add_req(REQ_ACTIVATE, 8'hFF, 4'hF, 4'hF, 7'h7F);
        add_req(REQ_REL_STREAM, 8'h00, 4'hF, 4'h0, 7'h00);
        add_req(REQ_REL_OWNER, 8'h01, 4'h0, 4'h0, 7'h00);
        add_req(REQ_ACTIVATE, 8'h02, 4'h2, 4'h3, 7'h05);
        add_req(REQ_ACTIVATE, 8'h03, 4'h2, 4'h3, 7'h05);
        add_req(REQ_REL_STREAM, 8'h00, 4'h2, 4'h0, 7'h00); // one pitch, freed twice
        add_req(REQ_ACTIVATE, 8'h04, 4'h1, 4'h3, 7'h06);
        add_req(REQ_ACTIVATE, 8'h05, 4'h2, 4'h3, 7'h06);
        add_req(REQ_REL_OWNER, 8'h04, 4'h0, 4'h0, 7'h00);  // freed but still sounding
        add_req(REQ_REL_OWNER, 8'h04, 4'h0, 4'h0, 7'h00);  // nothing to free
        add_req(REQ_REL_ALL, 8'h00, 4'h0, 4'h0, 7'h00);

        for (int phase = 0; phase < 3; phase++) begin
            @(negedge aclk);
            send_gap_pct   = (phase == 0) ? 34 : (phase == 1) ? 60 : 0;
            recv_stall_pct = (phase == 0) ? 60 : (phase == 1) ? 34 : 0;
            if (phase == 0) fill_table();
            add_random(RANDOM_PER_PHASE);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("active_note_table verification clean");
        end else begin
            $display("active_note_table verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("active_note_table verification failed");
        $finish;
    end

endmodule
